// ===== design/rmrs_pkg.sv =====
// Package for the root move rank sorter: payload types, record type and key compare.
`default_nettype none

package rmrs_pkg;

    localparam int ENTRIES = 32;

    typedef struct packed {
        logic [7:0]         move_tag;
        logic [6:0]         depth;
        logic signed [15:0] low_bound;
        logic signed [15:0] high_bound;
        logic               last_entry;
    } load_t;

    typedef struct packed {
        logic [7:0]         out_move_tag;
        logic [6:0]         out_depth;
        logic signed [15:0] out_low_bound;
        logic signed [15:0] out_high_bound;
        logic               out_last;
    } sort_t;

    typedef struct packed {
        logic [7:0]         move_tag;
        logic [6:0]         depth;
        logic signed [15:0] low_bound;
        logic signed [15:0] high_bound;
    } rec_t;

    // One cell slot as seen by its neighbours.
    typedef struct packed {
        rec_t rec;
        logic valid;
    } slot_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    // True when a ranks strictly before b: greater depth, then greater bound sum.
    function automatic logic ranks_above(rec_t a, rec_t b);
        logic signed [16:0] sum_a;
        logic signed [16:0] sum_b;
        sum_a = 17'(a.low_bound) + 17'(a.high_bound);
        sum_b = 17'(b.low_bound) + 17'(b.high_bound);
        if (a.depth != b.depth) begin
            return a.depth > b.depth;
        end
        return sum_a > sum_b;
    endfunction

endpackage

`default_nettype wire

// ===== design/rmrs_cell.sv =====
// One cell of the insertion chain: holds one record and trades with its neighbours.
`default_nettype none

module rmrs_cell
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rmrs_pkg::cell_ctrl_t ctrl,
    input  wire rmrs_pkg::rec_t     new_rec,
    input  wire rmrs_pkg::slot_t    left,
    input  wire logic               left_gt,
    input  wire rmrs_pkg::slot_t    right,
    output rmrs_pkg::slot_t         slot,
    output logic                    gt
);

    rmrs_pkg::rec_t rec_reg;
    rmrs_pkg::rec_t rec_next;
    logic           valid_reg;
    logic           valid_next;

    // An empty cell always yields to the incoming record.
    assign gt = !valid_reg || rmrs_pkg::ranks_above(new_rec, rec_reg);

    always_comb
    begin
        rec_next   = rec_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            rec_next   = right.rec;
            valid_next = right.valid;
        end else if (ctrl.insert && gt) begin
            if (left_gt) begin
                rec_next   = left.rec;
                valid_next = left.valid;
            end else begin
                rec_next   = new_rec;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign slot.rec   = rec_reg;
    assign slot.valid = valid_reg;

endmodule

`default_nettype wire

// ===== design/root_move_rank_sort.sv =====
// Top level of the root move rank sorter: chain of insertion cells and drain control.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------
//   load    | in        | load_valid, load_stall | load_data (rmrs_pkg::load_t)
//   sort    | out       | sort_valid, sort_stall | sort_data (rmrs_pkg::sort_t)
//
// Load requests are taken back to back while loading: every cell compares the new record
// with its own in parallel and the chain opens a gap at the insertion point in the same cycle.
// After the request marked last, the chain drains one record per cycle while the output
// is not stalled, through the output register; load_stall is high then.
// Reset clears the cell valid bits and the state machine; record contents are not reset.
// A stalled output holds its register and the drain simply pauses.
`default_nettype none

module root_move_rank_sort
#(
    parameter int ENTRIES = rmrs_pkg::ENTRIES
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load_valid,
    output logic                 load_stall,
    input  wire rmrs_pkg::load_t load_data,
    output logic                 sort_valid,
    input  wire logic            sort_stall,
    output rmrs_pkg::sort_t      sort_data
);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                sort_valid_reg;
    logic                sort_valid_next;
    rmrs_pkg::sort_t     sort_data_reg;
    rmrs_pkg::sort_t     sort_data_next;

    rmrs_pkg::slot_t     slots [ENTRIES];
    logic [ENTRIES-1:0]  gts;
    logic [ENTRIES-1:0]  cell_valid;
    rmrs_pkg::rec_t      new_rec;
    rmrs_pkg::cell_ctrl_t ctrl;
    logic                load_accept;
    logic                pop;
    logic                store_full;

    assign load_stall  = (state_reg != ST_LOAD);
    assign load_accept = load_valid && !load_stall;

    // The store is full once the tail cell holds a record; further records are dropped.
    assign store_full = cell_valid[ENTRIES-1];

    // A drain step moves the head record out whenever the output register is free.
    assign pop = (state_reg == ST_DRAIN) && (!sort_valid_reg || !sort_stall);

    assign new_rec.move_tag   = load_data.move_tag;
    assign new_rec.depth      = load_data.depth;
    assign new_rec.low_bound  = load_data.low_bound;
    assign new_rec.high_bound = load_data.high_bound;

    assign ctrl.insert = load_accept && !store_full;
    assign ctrl.shift  = pop;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            rmrs_pkg::slot_t left_slot;
            rmrs_pkg::slot_t right_slot;
            logic            left_gt;

            if (gi == 0) begin : g_head
                assign left_slot = '0;
                assign left_gt   = 1'b0;
            end else begin : g_body
                assign left_slot = slots[gi-1];
                assign left_gt   = gts[gi-1];
            end

            if (gi == ENTRIES - 1) begin : g_tail
                assign right_slot = '0;
            end else begin : g_inner
                assign right_slot = slots[gi+1];
            end

            rmrs_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .new_rec (new_rec),
                .left    (left_slot),
                .left_gt (left_gt),
                .right   (right_slot),
                .slot    (slots[gi]),
                .gt      (gts[gi])
            );

            assign cell_valid[gi] = slots[gi].valid;
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        sort_valid_next = sort_valid_reg;
        sort_data_next  = sort_data_reg;

        if (sort_valid_reg && !sort_stall) begin
            sort_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (load_accept && load_data.last_entry) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pop) begin
                    sort_valid_next               = 1'b1;
                    sort_data_next.out_move_tag   = slots[0].rec.move_tag;
                    sort_data_next.out_depth      = slots[0].rec.depth;
                    sort_data_next.out_low_bound  = slots[0].rec.low_bound;
                    sort_data_next.out_high_bound = slots[0].rec.high_bound;
                    // The head is the final record when nothing stands behind it.
                    sort_data_next.out_last       = !cell_valid[1];
                    if (!cell_valid[1]) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_LOAD;
            sort_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sort_valid_reg <= sort_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sort_data_reg <= sort_data_next;
    end

    assign sort_valid = sort_valid_reg;
    assign sort_data  = sort_data_reg;

`ifndef NO_ASSERTIONS
    // Occupied cells always form an unbroken run from the head of the chain.
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + ENTRIES'(1))) == '0)
        else $error("cell valid bits are not a contiguous prefix");

    // While draining, the head cell must hold a record to hand out.
    a_drain_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> cell_valid[0])
        else $error("drain with an empty head cell");

    // A request marked last always starts a drain.
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (load_accept && load_data.last_entry) |=> (state_reg == ST_DRAIN))
        else $error("last request did not start a drain");
`endif

endmodule

`default_nettype wire

// ===== test/root_move_rank_sort_tb.sv =====
// Self-checking testbench for the root move rank sorter: directed table, random lists.
`timescale 1ns / 1ps

module root_move_rank_sort_tb;

    // Generous cycle budget. The slowest correct run has about 400 requests with long
    // sender gaps and about 400 results behind long receiver stalls.
    localparam int RUN_LIMIT = 200000;
    localparam int RANDOM_MOVES = 360;
    localparam int PLAN_ROWS = 13;

    // One row of the directed table. Where fixed is set, the single result of the list
    // is typed in by hand rather than taken from the sorter below.
    typedef struct {
        rmrs_pkg::load_t req;
        bit              fixed;
        rmrs_pkg::sort_t fixed_out;
    } plan_row_t;

    logic            clk;
    logic            rst_n;
    logic            load_valid;
    logic            load_stall;
    rmrs_pkg::load_t load_data;
    logic            sort_valid;
    logic            sort_stall;
    rmrs_pkg::sort_t sort_data;

    // Records of the list being loaded, in load order, and the sorted records still
    // to be seen on the output, oldest first.
    rmrs_pkg::rec_t  held_moves [rmrs_pkg::ENTRIES];
    int              held_count;
    rmrs_pkg::sort_t ranked_moves_due [$];
    rmrs_pkg::sort_t due_move;

    int          mismatches;
    int unsigned cycle_count;
    bit          feed_calm;
    bit          sink_calm;
    plan_row_t   plan [PLAN_ROWS];

    root_move_rank_sort uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_stall (load_stall),
        .load_data  (load_data),
        .sort_valid (sort_valid),
        .sort_stall (sort_stall),
        .sort_data  (sort_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // True when a must be emitted strictly ahead of b. Depth decides first; at equal
    // depth the bound sum does, formed at full integer width so it cannot wrap.
    function automatic bit outranks(rmrs_pkg::rec_t a, rmrs_pkg::rec_t b);
        int sum_a;
        int sum_b;
        sum_a = $signed(a.low_bound) + $signed(a.high_bound);
        sum_b = $signed(b.low_bound) + $signed(b.high_bound);
        if (a.depth != b.depth)
        begin
            return a.depth > b.depth;
        end
        return sum_a > sum_b;
    endfunction

    // Takes one accepted request into the held list. A request marked last sorts the
    // list stably by insertion and, where queue_burst is set, queues the whole burst.
    // Requests beyond the store size are dropped, but their last mark still counts.
    task automatic take_move(input rmrs_pkg::load_t req, input bit queue_burst);
        rmrs_pkg::rec_t  key;
        rmrs_pkg::rec_t  ranked [rmrs_pkg::ENTRIES];
        rmrs_pkg::sort_t emitted;
        int              i;
        int              j;
        if (held_count < rmrs_pkg::ENTRIES)
        begin
            held_moves[held_count] = {req.move_tag, req.depth, req.low_bound, req.high_bound};
            held_count++;
        end
        if (!req.last_entry)
        begin
            return;
        end
        for (i = 0; i < held_count; i++)
        begin
            key = held_moves[i];
            j = i;
            // Only a strictly higher rank moves past an earlier record, which keeps
            // records with equal keys in load order.
            while (j > 0 && outranks(key, ranked[j - 1]))
            begin
                ranked[j] = ranked[j - 1];
                j--;
            end
            ranked[j] = key;
        end
        if (queue_burst)
        begin
            for (i = 0; i < held_count; i++)
            begin
                emitted.out_move_tag   = ranked[i].move_tag;
                emitted.out_depth      = ranked[i].depth;
                emitted.out_low_bound  = ranked[i].low_bound;
                emitted.out_high_bound = ranked[i].high_bound;
                emitted.out_last       = (i == held_count - 1);
                ranked_moves_due.push_back(emitted);
            end
        end
        held_count = 0;
    endtask

    // Length of an idle stretch: mostly none, often short, now and then a long one.
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    // Score bounds lean towards the extremes and the points around zero, where the
    // bound sum is most likely to go wrong.
    function automatic logic [15:0] pick_bound();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Presents one request from a falling edge, after an optional gap, and holds it until
    // it is accepted. The task returns at the falling edge after acceptance, so a
    // following request with no gap keeps load_valid high throughout.
    task automatic offer(input rmrs_pkg::load_t req, input bit fixed,
                         input rmrs_pkg::sort_t fixed_out);
        int unsigned gap;
        gap = feed_calm ? 0 : idle_span();
        if (gap != 0)
        begin
            load_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        load_valid <= 1'b1;
        load_data  <= req;
        @(posedge clk);
        while (load_stall)
        begin
            @(posedge clk);
        end
        take_move(req, !fixed);
        if (fixed)
        begin
            ranked_moves_due.push_back(fixed_out);
        end
        @(negedge clk);
    endtask

    // Lowers load_valid and holds back until every queued result has been seen.
    task automatic drain_wait();
        load_valid <= 1'b0;
        @(negedge clk);
        while (ranked_moves_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Receiver: a short run of cycles ready, then a stall of random length. In calm
    // stretches it never stalls. Each falling edge carries one assignment at most.
    initial
    begin
        int unsigned run;
        int unsigned hold;
        sort_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run  = $urandom_range(1, 7);
            hold = sink_calm ? 0 : idle_span();
            repeat (run)
            begin
                @(negedge clk);
                sort_stall <= 1'b0;
            end
            repeat (hold)
            begin
                @(negedge clk);
                sort_stall <= 1'b1;
            end
        end
    end

    // Every result accepted is compared field by field with the oldest one queued.
    always @(posedge clk)
    begin
        if (rst_n && sort_valid && !sort_stall)
        begin
            if (ranked_moves_due.size() == 0)
            begin
                $error("sort result with none outstanding: out_move_tag %0h",
                       sort_data.out_move_tag);
                mismatches++;
            end
            else
            begin
                due_move = ranked_moves_due.pop_front();
                if (sort_data.out_move_tag !== due_move.out_move_tag)
                begin
                    $error("out_move_tag: expected %0h, got %0h",
                           due_move.out_move_tag, sort_data.out_move_tag);
                    mismatches++;
                end
                if (sort_data.out_depth !== due_move.out_depth)
                begin
                    $error("out_depth: expected %0d, got %0d",
                           due_move.out_depth, sort_data.out_depth);
                    mismatches++;
                end
                if (sort_data.out_low_bound !== due_move.out_low_bound)
                begin
                    $error("out_low_bound: expected %0d, got %0d",
                           $signed(due_move.out_low_bound), $signed(sort_data.out_low_bound));
                    mismatches++;
                end
                if (sort_data.out_high_bound !== due_move.out_high_bound)
                begin
                    $error("out_high_bound: expected %0d, got %0d",
                           $signed(due_move.out_high_bound), $signed(sort_data.out_high_bound));
                    mismatches++;
                end
                if (sort_data.out_last !== due_move.out_last)
                begin
                    $error("out_last: expected %0b, got %0b",
                           due_move.out_last, sort_data.out_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("root_move_rank_sort: mismatch");
            $finish;
        end
    end

    initial
    begin
        int unsigned     stored_sent;
        int unsigned     list_len;
        int unsigned     k;
        int unsigned     r;
        bit              paused_mid;
        rmrs_pkg::load_t req;
        rmrs_pkg::sort_t no_out;

        rst_n       = 1'b0;
        load_valid  = 1'b0;
        load_data   = '0;
        mismatches  = 0;
        cycle_count = 0;
        held_count  = 0;
        feed_calm   = 1'b0;
        sink_calm   = 1'b0;
        stored_sent = 0;
        paused_mid  = 1'b0;
        no_out      = '0;

        // Directed table. A single-record list comes out unchanged with out_last set,
        // so those rows carry their result typed in; the rest go through the sorter.
        // Fields: move_tag, depth, low_bound, high_bound, last_entry.
        plan[0]  = '{{8'hFF, 7'd127, 16'h7FFF, 16'h7FFF, 1'b1}, 1'b1,
                     {8'hFF, 7'd127, 16'h7FFF, 16'h7FFF, 1'b1}};
        plan[1]  = '{{8'h00, 7'd0, 16'h8000, 16'h8000, 1'b1}, 1'b1,
                     {8'h00, 7'd0, 16'h8000, 16'h8000, 1'b1}};
        // Eight records: ties on the full key in several splits of the bound sum, the
        // largest and smallest possible sums, and both depth extremes.
        plan[2]  = '{{8'h10, 7'd5, 16'h0000, 16'h0000, 1'b0}, 1'b0, no_out};
        plan[3]  = '{{8'h11, 7'd5, 16'h0064, 16'hFF9C, 1'b0}, 1'b0, no_out};
        plan[4]  = '{{8'h12, 7'd127, 16'h8000, 16'h8000, 1'b0}, 1'b0, no_out};
        plan[5]  = '{{8'h13, 7'd5, 16'h7FFF, 16'h7FFF, 1'b0}, 1'b0, no_out};
        plan[6]  = '{{8'h14, 7'd0, 16'h7FFF, 16'h7FFF, 1'b0}, 1'b0, no_out};
        plan[7]  = '{{8'h15, 7'd5, 16'h8000, 16'h8000, 1'b0}, 1'b0, no_out};
        plan[8]  = '{{8'h16, 7'd127, 16'h8000, 16'h8001, 1'b0}, 1'b0, no_out};
        plan[9]  = '{{8'h17, 7'd5, 16'hFFFF, 16'h0001, 1'b1}, 1'b0, no_out};
        // Two records identical but for the tag: load order must survive.
        plan[10] = '{{8'hA5, 7'd64, 16'h1234, 16'hEDCC, 1'b0}, 1'b0, no_out};
        plan[11] = '{{8'h5A, 7'd64, 16'h1234, 16'hEDCC, 1'b1}, 1'b0, no_out};
        plan[12] = '{{8'h5A, 7'd64, 16'hFFFF, 16'h0001, 1'b1}, 1'b1,
                     {8'h5A, 7'd64, 16'hFFFF, 16'h0001, 1'b1}};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        feed_calm = 1'b1;
        sink_calm = 1'b1;
        for (k = 0; k < PLAN_ROWS; k++)
        begin
            offer(plan[k].req, plan[k].fixed, plan[k].fixed_out);
        end
        feed_calm = 1'b0;
        sink_calm = 1'b0;
        // Hold the sender back until the directed results are all out.
        drain_wait();

        // Random lists. Most are short; some fill the store exactly, and some run past
        // it so that the last mark lands on a dropped request. Depths cluster at a few
        // values so that secondary-key ties and stability are exercised constantly.
        while (stored_sent < RANDOM_MOVES)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                list_len = $urandom_range(33, 36);
            end
            else if (r < 14)
            begin
                list_len = rmrs_pkg::ENTRIES;
            end
            else if (r < 30)
            begin
                list_len = 1;
            end
            else
            begin
                list_len = $urandom_range(2, 12);
            end
            feed_calm = ($urandom_range(0, 5) == 0);
            sink_calm = ($urandom_range(0, 5) == 0);
            for (k = 0; k < list_len; k++)
            begin
                req.move_tag = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: req.depth = 7'($urandom_range(0, 3));
                    5:             req.depth = 7'd0;
                    6:             req.depth = 7'd127;
                    default:       req.depth = 7'($urandom_range(0, 127));
                endcase
                req.low_bound  = pick_bound();
                req.high_bound = pick_bound();
                req.last_entry = (k == list_len - 1);
                offer(req, 1'b0, no_out);
                if (k < rmrs_pkg::ENTRIES)
                begin
                    stored_sent++;
                end
            end
            if (!paused_mid && stored_sent >= RANDOM_MOVES / 2)
            begin
                paused_mid = 1'b1;
                drain_wait();
            end
        end

        load_valid <= 1'b0;
        @(negedge clk);
        while (ranked_moves_due.size() != 0)
        begin
            @(negedge clk);
        end
        // Wait past the end of a burst of a full store, so that any stray result can
        // show up.
        repeat (rmrs_pkg::ENTRIES + 16) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("root_move_rank_sort: match");
        end
        else
        begin
            $display("root_move_rank_sort: mismatch");
        end
        $finish;
    end

endmodule
